[rtl/aabo_pkg.sv]
`timescale 1ns / 1ps

package aabo_pkg;

  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned PROD_W    = 2 * CHAN_W;       // 8x8 product
  localparam int unsigned WIDE_W    = 3 * CHAN_W;       // 8x8x8 product
  localparam int unsigned NUM_W     = PROD_W + 1;       // sum of two products
  localparam int unsigned N_COLOR   = 3;                // red, green, blue
  localparam int unsigned N_DIV     = CHAN_W;           // one quotient bit per stage
  localparam int unsigned N_FRONT   = 4;                // stages ahead of the divider
  localparam int unsigned N_STAGE   = N_FRONT + N_DIV + 1;
  localparam int unsigned IN_W      = 8 * CHAN_W;
  localparam int unsigned OUT_W     = 4 * CHAN_W;

  localparam logic [CHAN_W-1:0] FULL_ALPHA = 8'd255;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [WIDE_W-1:0] wide_t;
  typedef logic [NUM_W-1:0]  num_t;

  typedef struct packed {
    chan_t a;
    chan_t r;
    chan_t g;
    chan_t b;
  } pix_t;

  // products of the input pixel
  typedef struct packed {
    logic                     bypass;
    pix_t                     dst;
    chan_t                    sa;
    prod_t                    t;      // dst_alpha * (255 - src_alpha)
    prod_t [N_COLOR-1:0]      ps;     // src_c * src_alpha
    chan_t [N_COLOR-1:0]      dc;
  } st1_t;

  // result alpha, wide destination terms
  typedef struct packed {
    logic                     bypass;
    pix_t                     dst;
    chan_t                    ra;
    prod_t [N_COLOR-1:0]      ps;
    wide_t [N_COLOR-1:0]      x;      // dst_c * t
  } st2_t;

  // estimate of x / 255, low by at most one
  typedef struct packed {
    logic                     bypass;
    pix_t                     dst;
    chan_t                    ra;
    prod_t [N_COLOR-1:0]      ps;
    wide_t [N_COLOR-1:0]      x;
    prod_t [N_COLOR-1:0]      qe;
  } st3_t;

  // dividend per channel
  typedef struct packed {
    logic                     bypass;
    pix_t                     dst;
    chan_t                    ra;
    num_t  [N_COLOR-1:0]      num;
  } st4_t;

  // restoring divider stage
  typedef struct packed {
    logic                     bypass;
    pix_t                     dst;
    chan_t                    ra;
    num_t  [N_COLOR-1:0]      rem;
    chan_t [N_COLOR-1:0]      quo;
    logic  [N_COLOR-1:0]      sat;
  } dv_t;

  // floor(t / 255), exact for any t up to 255 * 255
  function automatic chan_t div255_16(input prod_t t);
    logic [PROD_W:0] s;
    s = {1'b0, t} + {{(PROD_W+1-CHAN_W){1'b0}}, t[PROD_W-1:CHAN_W]} + 17'd1;
    return s[PROD_W-1:CHAN_W];
  endfunction

  // floor(x / 255) estimate for 24-bit x; result is q or q-1
  function automatic prod_t div255_est(input wide_t x);
    logic [WIDE_W:0] s;
    s = {1'b0, x}
      + {{(CHAN_W+1){1'b0}}, x[WIDE_W-1:CHAN_W]}
      + {{(PROD_W+1){1'b0}}, x[WIDE_W-1:PROD_W]};
    return s[WIDE_W-1:CHAN_W];
  endfunction

endpackage

[rtl/argb_alpha_blend_over.sv]
`timescale 1ns / 1ps

// Porter-Duff "over" blend of one non-premultiplied ARGB8888 source pixel
// onto one destination pixel, one pixel pair per clock when the output is not stalled.
//
// Input stream (s_*): one word carries both pixels. Output stream (m_*):
// one word carries the composite pixel. A word moves on a rising edge with
// tvalid and tready both high.
//
// A word passes 13 register stages to m_tvalid, the first loaded at the
// accepting edge. Throughput: one word per cycle while m_tready is high.
// The depth is set by the colour divide, a restoring divider that resolves
// one quotient bit per stage (8 stages), behind four stages of multiplies
// and divide-by-255 reduction, plus the output register.
//
// Each stage holds a valid bit and advances when it is empty or when the
// stage after it advances, so bubbles collapse and the input keeps taking
// words while a result waits at the output until the pipe fills. A stall
// at m_tready holds every full stage; nothing is dropped or repeated.
//
// rst (synchronous, active high) clears all valid bits; the pipe is empty.

module argb_alpha_blend_over
  import aabo_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // dst_alpha, dst_red, dst_green, dst_blue,
  // src_alpha, src_red, src_green, src_blue (8 bits each, low to high)
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // out_alpha, out_red, out_green, out_blue (8 bits each, low to high)
  output logic [OUT_W-1:0] m_tdata
);

  // stage valid bits and advance enables
  logic [N_STAGE-1:0] vld;
  logic [N_STAGE:0]   en;

  st1_t s1, s1_next;
  st2_t s2, s2_next;
  st3_t s3, s3_next;
  st4_t s4, s4_next;
  dv_t  dv      [N_DIV];
  dv_t  dv_next [N_DIV];
  logic [OUT_W-1:0] out_data, out_next;

  // ready chain from the output back
  always_comb begin
    en[N_STAGE] = m_tready;
    for (int i = N_STAGE - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  // no word is taken while in reset
  assign s_tready = en[0] && !rst;
  assign m_tvalid = vld[N_STAGE-1];
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < N_STAGE; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 1: unpack, 8x8 products
  always_comb begin
    chan_t inv_sa;
    s1_next.dst.a = s_tdata[0*CHAN_W +: CHAN_W];
    s1_next.dst.r = s_tdata[1*CHAN_W +: CHAN_W];
    s1_next.dst.g = s_tdata[2*CHAN_W +: CHAN_W];
    s1_next.dst.b = s_tdata[3*CHAN_W +: CHAN_W];
    s1_next.sa    = s_tdata[4*CHAN_W +: CHAN_W];
    s1_next.bypass = (s1_next.sa == '0);   // transparent source
    inv_sa = FULL_ALPHA - s1_next.sa;
    s1_next.t = PROD_W'(s1_next.dst.a) * PROD_W'(inv_sa);
    for (int c = 0; c < N_COLOR; c++) begin
      s1_next.ps[c] = PROD_W'(s_tdata[(5+c)*CHAN_W +: CHAN_W]) * PROD_W'(s1_next.sa);
    end
    s1_next.dc[0] = s1_next.dst.r;
    s1_next.dc[1] = s1_next.dst.g;
    s1_next.dc[2] = s1_next.dst.b;
  end

  // stage 2: result alpha, dst_c * t
  always_comb begin
    s2_next.bypass = s1.bypass;
    s2_next.dst    = s1.dst;
    s2_next.ps     = s1.ps;
    s2_next.ra     = s1.sa + div255_16(s1.t);   // never above 255
    for (int c = 0; c < N_COLOR; c++) begin
      s2_next.x[c] = WIDE_W'(s1.dc[c]) * WIDE_W'(s1.t);
    end
  end

  // stage 3: estimate x / 255
  always_comb begin
    s3_next.bypass = s2.bypass;
    s3_next.dst    = s2.dst;
    s3_next.ra     = s2.ra;
    s3_next.ps     = s2.ps;
    s3_next.x      = s2.x;
    for (int c = 0; c < N_COLOR; c++) begin
      s3_next.qe[c] = div255_est(s2.x[c]);
    end
  end

  // stage 4: correct the estimate, form the dividend
  always_comb begin
    wide_t qx;
    wide_t r;
    prod_t q;
    s4_next.bypass = s3.bypass;
    s4_next.dst    = s3.dst;
    s4_next.ra     = s3.ra;
    for (int c = 0; c < N_COLOR; c++) begin
      qx = {s3.qe[c], {CHAN_W{1'b0}}} - WIDE_W'(s3.qe[c]);   // qe * 255
      r  = s3.x[c] - qx;
      q  = (r >= WIDE_W'(FULL_ALPHA)) ? s3.qe[c] + PROD_W'(1) : s3.qe[c];
      s4_next.num[c] = NUM_W'(s3.ps[c]) + NUM_W'(q);
    end
  end

  // divider: stage k resolves quotient bit (7 - k)
  always_comb begin
    num_t trial;
    for (int k = 0; k < N_DIV; k++) begin
      if (k == 0) begin
        dv_next[k].bypass = s4.bypass;
        dv_next[k].dst    = s4.dst;
        dv_next[k].ra     = s4.ra;
        dv_next[k].rem    = s4.num;
        dv_next[k].quo    = '0;
        for (int c = 0; c < N_COLOR; c++) begin
          // quotient would not fit in 8 bits
          dv_next[k].sat[c] = (s4.num[c] >= {1'b0, s4.ra, {CHAN_W{1'b0}}});
        end
      end else begin
        dv_next[k] = dv[k-1];
      end
      trial = NUM_W'(dv_next[k].ra) << (N_DIV - 1 - k);
      for (int c = 0; c < N_COLOR; c++) begin
        if (dv_next[k].rem[c] >= trial) begin
          dv_next[k].rem[c]             = dv_next[k].rem[c] - trial;
          dv_next[k].quo[c][N_DIV-1-k]  = 1'b1;
        end
      end
    end
  end

  // output word
  always_comb begin
    chan_t col [N_COLOR];
    for (int c = 0; c < N_COLOR; c++) begin
      col[c] = dv[N_DIV-1].sat[c] ? FULL_ALPHA : dv[N_DIV-1].quo[c];
    end
    if (dv[N_DIV-1].bypass) begin
      out_next = {dv[N_DIV-1].dst.b, dv[N_DIV-1].dst.g,
                  dv[N_DIV-1].dst.r, dv[N_DIV-1].dst.a};
    end else begin
      out_next = {col[2], col[1], col[0], dv[N_DIV-1].ra};
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1 <= s1_next;
    end
    if (en[1]) begin
      s2 <= s2_next;
    end
    if (en[2]) begin
      s3 <= s3_next;
    end
    if (en[3]) begin
      s4 <= s4_next;
    end
    for (int k = 0; k < N_DIV; k++) begin
      if (en[N_FRONT+k]) begin
        dv[k] <= dv_next[k];
      end
    end
    if (en[N_STAGE-1]) begin
      out_data <= out_next;
    end
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top
  import aabo_pkg::*;
();

  localparam int unsigned OPAQUE      = 255;
  localparam int          N_RANDOM    = 1300;
  localparam int          HOLD_AFTER  = 200;     // output words seen before the long stall
  localparam int          HOLD_CYCLES = 300;     // well past the pipe depth
  localparam int          DRAIN       = 30;      // margin past the pipe depth
  localparam int          CYCLE_LIMIT = 200000;

  logic             clk;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  // dst_alpha, dst_red, dst_green, dst_blue,
  // src_alpha, src_red, src_green, src_blue (8 bits each, low to high)
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  // out_alpha, out_red, out_green, out_blue (8 bits each, low to high)
  logic [OUT_W-1:0] m_tdata;

  // composites still owed by the pipe, oldest first
  pix_t composites_due [$];
  int   errors = 0;
  int   cycles = 0;

  // pacing state: a run of words either has no gaps at all or random ones
  int   send_run = 0;
  bit   send_calm = 1'b0;
  int   take_run = 0;
  bit   take_calm = 1'b0;

  string chan_name [4] = '{"blue", "green", "red", "alpha"};

  argb_alpha_blend_over uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Over composite of non-premultiplied ARGB pixels. Colours are laid out
  // b, g, r from bit 0 up inside pix_t, hence the byte slicing below.
  function automatic pix_t blend_over(input pix_t dst, input pix_t src);
    pix_t        res;
    int unsigned sa, da, keep, ra, sc, dc, num, q;
    if (src.a == 8'd0)
      return dst;                       // transparent source: destination as is
    sa   = src.a;
    da   = dst.a;
    keep = OPAQUE - sa;                 // share of the destination that shows
    ra   = sa + (da * keep) / OPAQUE;
    res  = '0;
    res.a = ra[7:0];
    if (ra != 0) begin
      for (int k = 0; k < 3; k++) begin
        sc  = src[8*k +: 8];
        dc  = dst[8*k +: 8];
        num = sc * sa + (dc * da * keep) / OPAQUE;
        q   = num / ra;
        // floors in the alpha term can push the quotient past full scale
        res[8*k +: 8] = (q > OPAQUE) ? 8'hFF : q[7:0];
      end
    end
    return res;
  endfunction

  function automatic int draw_wait(inout int run_left, inout bit calm);
    if (run_left == 0) begin
      run_left = $urandom_range(8, 48);
      calm     = ($urandom_range(0, 2) == 0);
    end
    run_left--;
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  // Offer one pixel pair, hold it until taken, then log what must come out.
  task automatic offer_pair(input pix_t dst, input pix_t src, input pix_t want);
    int gap;
    gap = draw_wait(send_run, send_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {src.b, src.g, src.r, src.a, dst.b, dst.g, dst.r, dst.a};
    do @(posedge clk); while (!s_tready);
    composites_due.push_back(want);
  endtask

  // Directed words, ARGB as 32'hAARRGGBB. A row with known set carries its
  // expected composite; the rest go through blend_over.
  typedef struct packed {
    logic known;
    pix_t dst;
    pix_t src;
    pix_t want;
  } blend_case_t;

  localparam int N_CASES = 18;
  blend_case_t blend_cases [N_CASES] = '{
    // both fully clear
    {1'b1, 32'h00000000, 32'h00000000, 32'h00000000},
    // transparent source keeps the destination, including its alpha
    {1'b1, 32'hFFFFFFFF, 32'h00FFFFFF, 32'hFFFFFFFF},
    {1'b1, 32'h00112233, 32'h00FFFFFF, 32'h00112233},
    {1'b1, 32'h5AA53CC3, 32'h00000000, 32'h5AA53CC3},
    // opaque source replaces the destination
    {1'b1, 32'h00000000, 32'hFF123456, 32'hFF123456},
    {1'b1, 32'hFFFFFFFF, 32'hFF000000, 32'hFF000000},
    {1'b1, 32'h80ABCDEF, 32'hFFFFFFFF, 32'hFFFFFFFF},
    // clear destination: source colours come back exactly
    {1'b1, 32'h00FFFFFF, 32'h80123456, 32'h80123456},
    // quotient lands at 381, must clip to full scale
    {1'b1, 32'h02FFFFFF, 32'h01FFFFFF, 32'h02FFFFFF},
    {1'b0, 32'hFFFFFFFF, 32'h01000000, 32'h00000000},
    {1'b0, 32'hFF000000, 32'h01FFFFFF, 32'h00000000},
    {1'b0, 32'h80808080, 32'h80808080, 32'h00000000},
    {1'b0, 32'hFFFFFFFF, 32'hFE000000, 32'h00000000},
    {1'b0, 32'h017F7F7F, 32'h7F80FF00, 32'h00000000},
    {1'b0, 32'hFF0000FF, 32'h7FFF0000, 32'h00000000},
    {1'b0, 32'h55AA55AA, 32'hAA55AA55, 32'h00000000},
    {1'b0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h00000000},
    {1'b0, 32'h01010101, 32'hFEFEFEFE, 32'h00000000}
  };

  // stimulus and end of run
  initial begin
    pix_t dst, src;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < N_CASES; n++) begin
      dst = blend_cases[n].dst;
      src = blend_cases[n].src;
      offer_pair(dst, src,
                 blend_cases[n].known ? blend_cases[n].want : blend_over(dst, src));
    end

    // random pairs, leaning on the alpha extremes and on bright colours
    // where the clipping shows up
    for (int n = 0; n < N_RANDOM; n++) begin
      dst = $urandom;
      src = $urandom;
      case ($urandom_range(0, 7))
        0: src.a = 8'h00;
        1: src.a = 8'hFF;
        2: src.a = 8'h01;
        default: ;
      endcase
      case ($urandom_range(0, 7))
        0: dst.a = 8'h00;
        1: dst.a = 8'hFF;
        default: ;
      endcase
      if ($urandom_range(0, 7) == 0) begin
        {src.r, src.g, src.b} = 24'hFFFFFF;
        {dst.r, dst.g, dst.b} = 24'hFFFFFF;
      end
      offer_pair(dst, src, blend_over(dst, src));
    end
    s_tvalid <= 1'b0;

    while (composites_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // output ready: random stalls per word, one long hold-off so the pipe
  // backs up and s_tready has to drop
  initial begin
    int stall;
    int taken;
    bit held;
    taken = 0;
    held  = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && taken == HOLD_AFTER) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end else begin
        stall = draw_wait(take_run, take_calm);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  // output check, channel by channel against the oldest composite owed
  always @(posedge clk) begin
    pix_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24]};
      if (composites_due.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
      end else begin
        want = composites_due.pop_front();
        for (int k = 3; k >= 0; k--) begin
          if (got[8*k +: 8] !== want[8*k +: 8]) begin
            $display("%0t: %s expected %h got %h", $time, chan_name[k],
                     want[8*k +: 8], got[8*k +: 8]);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d words outstanding", $time, composites_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
